### hdl/lcg48_pkg.sv
// shared types and constants of the 48-bit congruential generator
`timescale 1ns / 1ps
package lcg48_pkg;

  localparam logic [2:0] KindSetSeed    = 3'd0;
  localparam logic [2:0] KindCarverSeed = 3'd1;
  localparam logic [2:0] KindRegionSeed = 3'd2;
  localparam logic [2:0] KindBits       = 3'd3;
  localparam logic [2:0] KindBounded    = 3'd4;
  localparam logic [2:0] KindLong       = 3'd5;
  localparam logic [2:0] KindDouble     = 3'd6;

  localparam logic CfgMultiplier = 1'b0;
  localparam logic CfgAddend     = 1'b1;

  localparam logic [47:0] MultReset   = 48'd25214903917;
  localparam logic [47:0] AddendReset = 48'd11;
  localparam logic [63:0] RegionXMul  = 64'd341873128712;
  localparam logic [63:0] RegionZMul  = 64'd132897987541;
  localparam int unsigned RejectLimit = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,   // seed step as three product chunks
    ST_DRAW,   // consume the fresh seed
    ST_MUL,    // two 64-bit coordinate products for carver / region
    ST_DIV,    // restoring remainder, one bit per cycle
    ST_CHECK,  // rejection test of a bounded draw
    ST_DONE
  } state_e;

endpackage

### hdl/lcg48_random_generator.sv
// 48-bit congruential generator with one shared 32x32 multiplier and a serial divider
// set seed and undefined kinds go straight to done; bits, bounded, long and double run seed
//   steps and draws, carver seed adds coordinate products, region seed runs products only
// bounded draws with rejection: a serial remainder and a check per draw, at most 64 draws
// one item at a time: in_stall_o is high outside idle; a finished result waits in done while
//   a stalled result still holds the output register; reset zeroes the seed, loads defaults
`timescale 1ns / 1ps
module lcg48_random_generator
  import lcg48_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] seed_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] salt_i,
  input  logic [5:0]  draw_bits_i,
  input  logic [31:0] bound_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [63:0] value_o,
  output logic [47:0] seed_after_o
);

  state_e state_q, state_d;

  logic [47:0] mult_q, addend_q, seed_q, seed_d;
  logic [2:0]  kind_q;
  logic [63:0] sv_q;
  logic [63:0] x_q, z_q;
  logic [63:0] s_q;              // structure seed plus salt
  logic [5:0]  nb_q;
  logic [31:0] bnd_q;
  logic        pow2_q;
  logic [6:0]  tries_q, tries_d;
  logic [1:0]  draw_q, draw_d;   // draw index within an item
  logic [63:0] acc_q, acc_d;
  logic [63:0] la_q, la_d;       // first long of carver
  logic [63:0] lb_q, lb_d;
  logic [63:0] prod_q, prod_d;   // running product
  logic [63:0] p1_q, p1_d;       // first coordinate product
  logic [1:0]  chunk_q, chunk_d;
  logic        pidx_q, pidx_d;
  logic [30:0] bits31_q, bits31_d;
  logic [30:0] dsh_q, dsh_d;
  logic [31:0] rem_q, rem_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [63:0] val_q, val_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] oval_q, oval_d;
  logic [47:0] oseed_q, oseed_d;

  // shared 32x32 unsigned multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = ma * mb;

  // top bits helper
  function automatic logic [63:0] topbits(input logic [47:0] s, input logic [5:0] n);
    logic [47:0] t;
    begin
      t = s >> (6'd48 - n);
      if (n == 6'd0) topbits = 64'd0;
      else topbits = {{32{t[31]}}, t[31:0]};
    end
  endfunction

  // number of bits for the current draw
  logic [5:0] nbits;
  always_comb begin
    nbits = 6'd32;
    case (kind_q)
      KindBits:    nbits = nb_q;
      KindBounded: nbits = 6'd31;
      KindDouble:  nbits = (draw_q == 2'd0) ? 6'd26 : 6'd27;
      default:     nbits = 6'd32;
    endcase
  end

  logic [63:0] dv;
  assign dv = topbits(seed_q, nbits);

  // 64x64 product mod 2^64 in three chunks: a0*c0, a1*c0, a0*c1
  logic [63:0] opa, opc;
  always_comb begin
    opa = {16'd0, seed_q};
    opc = {16'd0, mult_q};
    if (state_q == ST_MUL) begin
      if (kind_q == KindCarverSeed) opa = pidx_q ? lb_q : la_q;
      else opa = pidx_q ? RegionZMul : RegionXMul;
      opc = pidx_q ? z_q : x_q;
    end
  end

  always_comb begin
    ma = opa[31:0];
    mb = opc[31:0];
    case (state_q)
      ST_STEP, ST_MUL: begin
        case (chunk_q)
          2'd0:    begin ma = opa[31:0];  mb = opc[31:0];  end
          2'd1:    begin ma = opa[63:32]; mb = opc[31:0];  end
          default: begin ma = opa[31:0];  mb = opc[63:32]; end
        endcase
      end
      ST_DRAW: begin
        ma = bnd_q;
        mb = {1'b0, seed_q[47:17]};
      end
      default: ;
    endcase
  end

  logic [63:0] term, prod_sum;
  assign term     = (chunk_q == 2'd0) ? mp : {mp[31:0], 32'd0};
  assign prod_sum = (chunk_q == 2'd0) ? term : prod_q + term;

  logic [31:0] b_sat;
  assign b_sat = (bound_i > 32'h8000_0000) ? 32'h8000_0000 : bound_i;

  logic [31:0] dshift;
  logic [32:0] trial;
  assign dshift = {rem_q[30:0], dsh_q[30]};
  assign trial  = {1'b0, dshift} - {1'b0, bnd_q};

  logic [31:0] chk;
  assign chk = {1'b0, bits31_q} - rem_q + bnd_q - 32'd1;

  always_comb begin
    state_d  = state_q;
    seed_d   = seed_q;
    tries_d  = tries_q;
    draw_d   = draw_q;
    acc_d    = acc_q;
    la_d     = la_q;
    lb_d     = lb_q;
    prod_d   = prod_q;
    p1_d     = p1_q;
    chunk_d  = chunk_q;
    pidx_d   = pidx_q;
    bits31_d = bits31_q;
    dsh_d    = dsh_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    val_d    = val_q;
    ovalid_d = ovalid_q;
    oval_d   = oval_q;
    oseed_d  = oseed_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          draw_d  = 2'd0;
          tries_d = 7'd1;
          chunk_d = 2'd0;
          pidx_d  = 1'b0;
          case (kind_i)
            KindSetSeed: begin
              seed_d  = seed_value_i[47:0] ^ mult_q;
              state_d = ST_DONE;
            end
            KindCarverSeed: begin
              seed_d  = seed_value_i[47:0] ^ mult_q;
              state_d = ST_STEP;
            end
            KindRegionSeed: state_d = ST_MUL;
            KindBits, KindBounded, KindLong, KindDouble: state_d = ST_STEP;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_STEP: begin
        prod_d  = prod_sum;
        chunk_d = chunk_q + 2'd1;
        if (chunk_q == 2'd2) begin
          seed_d  = prod_sum[47:0] + addend_q;
          chunk_d = 2'd0;
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        draw_d  = draw_q + 2'd1;
        state_d = ST_STEP;
        case (kind_q)
          KindBits: begin
            val_d   = dv;
            state_d = ST_DONE;
          end
          KindBounded: begin
            if (pow2_q) begin
              val_d   = mp >> 31;
              state_d = ST_DONE;
            end else begin
              bits31_d = seed_q[47:17];
              dsh_d    = seed_q[47:17];
              rem_d    = 32'd0;
              dcnt_d   = 5'd0;
              state_d  = ST_DIV;
            end
          end
          KindLong: begin
            if (draw_q == 2'd0) acc_d = {dv[31:0], 32'd0};
            else begin
              val_d   = acc_q + dv;
              state_d = ST_DONE;
            end
          end
          KindDouble: begin
            if (draw_q == 2'd0) acc_d = dv << 27;
            else begin
              val_d   = acc_q + dv;
              state_d = ST_DONE;
            end
          end
          KindCarverSeed: begin
            // four 32-bit draws make two longs
            case (draw_q)
              2'd0: acc_d = {dv[31:0], 32'd0};
              2'd1: la_d = acc_q + dv;
              2'd2: acc_d = {dv[31:0], 32'd0};
              default: begin
                lb_d    = acc_q + dv;
                chunk_d = 2'd0;
                pidx_d  = 1'b0;
                state_d = ST_MUL;
              end
            endcase
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_MUL: begin
        prod_d  = prod_sum;
        chunk_d = chunk_q + 2'd1;
        if (chunk_q == 2'd2) begin
          chunk_d = 2'd0;
          if (!pidx_q) begin
            p1_d   = prod_sum;
            pidx_d = 1'b1;
          end else begin
            if (kind_q == KindCarverSeed)
              seed_d = 48'(p1_q ^ prod_sum ^ sv_q) ^ mult_q;
            else
              seed_d = 48'(p1_q + prod_sum + s_q) ^ mult_q;
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        rem_d  = trial[32] ? dshift : trial[31:0];
        dsh_d  = {dsh_q[29:0], 1'b0};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd30) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // after the last allowed draw the remainder stands unchecked
        if (!chk[31] || tries_q == 7'(RejectLimit)) begin
          val_d   = {32'd0, rem_q};
          state_d = ST_DONE;
        end else begin
          tries_d = tries_q + 7'd1;
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          case (kind_q)
            KindSetSeed, KindCarverSeed, KindRegionSeed: oval_d = {16'd0, seed_q};
            KindBits, KindBounded, KindLong, KindDouble: oval_d = val_q;
            default: oval_d = 64'd0;
          endcase
          oseed_d  = seed_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seed_q   <= 48'd0;
      mult_q   <= MultReset;
      addend_q <= AddendReset;
      kind_q   <= KindSetSeed;
      sv_q     <= 64'd0;
      x_q      <= 64'd0;
      z_q      <= 64'd0;
      s_q      <= 64'd0;
      nb_q     <= 6'd0;
      bnd_q    <= 32'd0;
      pow2_q   <= 1'b0;
      tries_q  <= 7'd0;
      draw_q   <= 2'd0;
      acc_q    <= 64'd0;
      la_q     <= 64'd0;
      lb_q     <= 64'd0;
      prod_q   <= 64'd0;
      p1_q     <= 64'd0;
      chunk_q  <= 2'd0;
      pidx_q   <= 1'b0;
      bits31_q <= 31'd0;
      dsh_q    <= 31'd0;
      rem_q    <= 32'd0;
      dcnt_q   <= 5'd0;
      val_q    <= 64'd0;
      ovalid_q <= 1'b0;
      oval_q   <= 64'd0;
      oseed_q  <= 48'd0;
    end else begin
      state_q  <= state_d;
      seed_q   <= seed_d;
      tries_q  <= tries_d;
      draw_q   <= draw_d;
      acc_q    <= acc_d;
      la_q     <= la_d;
      lb_q     <= lb_d;
      prod_q   <= prod_d;
      p1_q     <= p1_d;
      chunk_q  <= chunk_d;
      pidx_q   <= pidx_d;
      bits31_q <= bits31_d;
      dsh_q    <= dsh_d;
      rem_q    <= rem_d;
      dcnt_q   <= dcnt_d;
      val_q    <= val_d;
      ovalid_q <= ovalid_d;
      oval_q   <= oval_d;
      oseed_q  <= oseed_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMultiplier: mult_q <= cfg_data_i;
          CfgAddend:     addend_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_valid_i) begin
        kind_q <= kind_i;
        sv_q   <= seed_value_i;
        x_q    <= {{32{coord_x_i[31]}}, coord_x_i};
        z_q    <= {{32{coord_z_i[31]}}, coord_z_i};
        s_q    <= seed_value_i + {{32{salt_i[31]}}, salt_i};
        nb_q   <= (draw_bits_i > 6'd32) ? 6'd32 : draw_bits_i;
        bnd_q  <= b_sat;
        pow2_q <= (b_sat & (b_sat - 32'd1)) == 32'd0;
      end
    end
  end

  assign value_o      = oval_q;
  assign seed_after_o = oseed_q;

endmodule
